// File: rtl/core/bss_pkg.sv
// shared types, constants and helpers for the bounded substring search
`default_nettype none
package bss_pkg;

    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 32;
    localparam int LEN_W      = 5;
    localparam int NEEDLE_CAP = 16;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 64;
    localparam int LIMIT_W    = 32;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [1:0] {
        ST_SEARCH = 2'd0,
        ST_FOUND  = 2'd1,
        ST_MISS   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_NEEDLE_LO  = 2'd0,
        REG_NEEDLE_HI  = 2'd1,
        REG_NEEDLE_LEN = 2'd2,
        REG_LIMIT      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [DATA_W-1:0]  needle_lo;
        logic [DATA_W-1:0]  needle_hi;
        logic [LEN_W-1:0]   needle_len;
        logic [LIMIT_W-1:0] limit;
    } t_cfg;

    typedef struct packed {
        t_byte hay_byte;
        logic  first_byte;
        logic  is_end;
    } t_item;

    // needle byte k out of the two needle registers
    function automatic t_byte needle_at(input t_cfg c, input logic [3:0] k);
        t_byte b;
        if (k[3]) begin
            b = c.needle_hi[{k[2:0], 3'b000} +: BYTE_W];
        end else begin
            b = c.needle_lo[{k[2:0], 3'b000} +: BYTE_W];
        end
        return b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/bss_in_if.sv
// haystack byte channel
`default_nettype none
interface bss_in_if import bss_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte hay_byte;
    logic  first_byte;

    modport source (output valid, output hay_byte, output first_byte, input ready);
    modport sink   (input valid, input hay_byte, input first_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bss_out_if.sv
// search result channel
`default_nettype none
interface bss_out_if import bss_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         search_status;
    logic [IDX_W-1:0]   match_start;

    modport source (output valid, output search_status, output match_start, input ready);
    modport sink   (input valid, input search_status, input match_start, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bss_cfg.sv
// apb register file for needle, needle length and search limit
`default_nettype none
module bss_cfg import bss_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx sel;
    logic     wr_en;

    assign sel    = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en && pready) begin
            case (sel)
                REG_NEEDLE_LO:  r_cfg.needle_lo  <= pwdata;
                REG_NEEDLE_HI:  r_cfg.needle_hi  <= pwdata;
                REG_NEEDLE_LEN: r_cfg.needle_len <= pwdata[LEN_W-1:0];
                REG_LIMIT:      r_cfg.limit      <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_NEEDLE_LO:  prdata = r_cfg.needle_lo;
            REG_NEEDLE_HI:  prdata = r_cfg.needle_hi;
            REG_NEEDLE_LEN: prdata = {{(DATA_W-LEN_W){1'b0}}, r_cfg.needle_len};
            REG_LIMIT:      prdata = {{(DATA_W-LIMIT_W){1'b0}}, r_cfg.limit};
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/bss_front.sv
// front end: takes haystack bytes, tags end of string, feeds the queue
`default_nettype none
module bss_front import bss_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bss_in_if.sink    i_hay,
    output logic      o_push,
    output t_item     o_item,
    input  wire logic i_q_ready
);

    logic  r_valid;
    t_item r_item;

    assign i_hay.ready = !r_valid || i_q_ready;
    assign o_push      = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_hay.ready) begin
            r_valid <= i_hay.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hay.valid && i_hay.ready) begin
            r_item.hay_byte   <= i_hay.hay_byte;
            r_item.first_byte <= i_hay.first_byte;
            r_item.is_end     <= (i_hay.hay_byte == '0);
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/bss_queue.sv
// short fifo between front and back ends
`default_nettype none
module bss_queue import bss_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_ready,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_pop
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic               push_ok;
    logic               pop_ok;

    assign o_ready = (r_count != (Q_PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/bss_back.sv
// back end: byte window, parallel needle compare, search status and result register
`default_nettype none
module bss_back import bss_pkg::*; #(
    parameter int NEEDLE_MAX = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_pop,
    bss_out_if.source  o_res
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(NEEDLE_MAX);

    t_byte            r_win [NEEDLE_MAX];
    logic [IDX_W-1:0] r_idx;
    t_status          r_status;
    logic [IDX_W-1:0] r_found;

    t_byte            n_win [NEEDLE_MAX];
    logic [IDX_W-1:0] n_idx;
    t_status          n_status;
    logic [IDX_W-1:0] n_found;

    logic             r_out_valid;
    t_status          r_out_status;
    logic [IDX_W-1:0] r_out_start;

    t_byte            cur_win [NEEDLE_MAX];
    t_byte            win_sh  [NEEDLE_MAX];
    logic [IDX_W-1:0] cur_idx;
    t_status          cur_status;
    logic [IDX_W-1:0] cur_found;
    logic [LEN_W-1:0] clamp_len;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] eff_m1;
    logic [NEEDLE_MAX-1:0] pos_ok;
    logic             hit;
    logic [IDX_W-1:0] start_idx;
    logic             take;

    assign take  = i_valid && (!r_out_valid || o_res.ready);
    assign o_pop = take;

    assign o_res.valid         = r_out_valid;
    assign o_res.search_status = r_out_status;
    assign o_res.match_start   = r_out_start;

    // needle stops at its first zero byte, and never exceeds the window
    always_comb begin
        clamp_len = (i_cfg.needle_len > MAX_LEN) ? MAX_LEN : i_cfg.needle_len;
        eff_len   = clamp_len;
        for (int k = NEEDLE_MAX - 1; k >= 0; k--) begin
            if ((LEN_W'(k) < clamp_len) && (needle_at(i_cfg, 4'(k)) == '0)) begin
                eff_len = LEN_W'(k);
            end
        end
    end

    assign eff_m1 = eff_len - LEN_W'(1);

    // first byte of a new string restarts from a clean state
    always_comb begin
        cur_status = i_item.first_byte ? ST_SEARCH : r_status;
        cur_idx    = i_item.first_byte ? '0 : r_idx;
        cur_found  = i_item.first_byte ? '0 : r_found;
        for (int j = 0; j < NEEDLE_MAX; j++) begin
            cur_win[j] = i_item.first_byte ? '0 : r_win[j];
        end
        win_sh[0] = i_item.hay_byte;
        for (int j = 1; j < NEEDLE_MAX; j++) begin
            win_sh[j] = cur_win[j-1];
        end
    end

    // window slot j holds needle byte eff_len-1-j
    always_comb begin
        for (int j = 0; j < NEEDLE_MAX; j++) begin
            pos_ok[j] = (LEN_W'(j) >= eff_len) ||
                        (win_sh[j] == needle_at(i_cfg, 4'(eff_m1 - LEN_W'(j))));
        end
        hit       = (&pos_ok) && (cur_idx >= {{(IDX_W-LEN_W){1'b0}}, eff_m1});
        start_idx = cur_idx - {{(IDX_W-LEN_W){1'b0}}, eff_m1};
    end

    always_comb begin
        n_status = cur_status;
        n_idx    = cur_idx;
        n_found  = cur_found;
        for (int j = 0; j < NEEDLE_MAX; j++) begin
            n_win[j] = cur_win[j];
        end
        if (cur_status == ST_SEARCH) begin
            if (eff_len == '0) begin
                n_status = ST_FOUND;
                n_found  = '0;
            end else if (i_item.is_end || (cur_idx >= i_cfg.limit)) begin
                n_status = ST_MISS;
            end else begin
                for (int j = 0; j < NEEDLE_MAX; j++) begin
                    n_win[j] = win_sh[j];
                end
                if (hit) begin
                    n_status = ST_FOUND;
                    n_found  = start_idx;
                end else if (cur_idx != '1) begin
                    n_idx = cur_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_SEARCH;
            r_idx    <= '0;
            r_found  <= '0;
            for (int j = 0; j < NEEDLE_MAX; j++) begin
                r_win[j] <= '0;
            end
        end else if (take) begin
            r_status <= n_status;
            r_idx    <= n_idx;
            r_found  <= n_found;
            for (int j = 0; j < NEEDLE_MAX; j++) begin
                r_win[j] <= n_win[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_status <= n_status;
            r_out_start  <= (n_status == ST_FOUND) ? n_found : '0;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/bounded_substring_search.sv
// bounded substring search: streams haystack bytes, reports first needle match
// a byte passes the front register and the queue before its result is registered in the back end
// throughput: one byte per cycle while results are accepted, set by the window compare
// and status update in the back end; a two-entry queue decouples front and back
// reset (synchronous, active low) clears configuration, window, index, status and queue
`default_nettype none
module bounded_substring_search import bss_pkg::*; #(
    parameter int NEEDLE_MAX = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    bss_in_if.sink                 i_hay,
    bss_out_if.source              o_res
);

    t_cfg  cfg;
    logic  push;
    t_item front_item;
    logic  q_ready;
    logic  q_valid;
    t_item q_item;
    logic  pop;

    bss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bss_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hay     (i_hay),
        .o_push    (push),
        .o_item    (front_item),
        .i_q_ready (q_ready)
    );

    bss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    bss_back #(
        .NEEDLE_MAX (NEEDLE_MAX)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

// File: tb/tb.sv
// testbench for the bounded substring search: directed and random haystacks against a predictor
`timescale 1ns / 1ps
module tb;
    import bss_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASES      = 8;
    localparam int PHASE_BYTES = 200;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] start;
    } t_search_result;

    // predicted search state and the results still to come from the block
    class search_scoreboard;
        logic [DATA_W-1:0]  needle_lo;
        logic [DATA_W-1:0]  needle_hi;
        logic [LEN_W-1:0]   needle_len;
        logic [LIMIT_W-1:0] limit;
        t_byte              window [NEEDLE_CAP];
        logic [IDX_W-1:0]   pos;
        t_status            status;
        logic [IDX_W-1:0]   found_at;
        t_search_result     awaited_results [$];
        int                 errors;
        int                 results_seen;
        int                 found_seen;
        int                 miss_seen;

        function new();
            needle_lo  = '0;
            needle_hi  = '0;
            needle_len = '0;
            limit      = '0;
            errors     = 0;
            results_seen = 0;
            found_seen = 0;
            miss_seen  = 0;
            restart_search();
        endfunction

        function void restart_search();
            foreach (window[k]) window[k] = '0;
            pos      = '0;
            status   = ST_SEARCH;
            found_at = '0;
        endfunction

        function void write_reg(t_reg_idx r, logic [DATA_W-1:0] v);
            case (r)
                REG_NEEDLE_LO:  needle_lo  = v;
                REG_NEEDLE_HI:  needle_hi  = v;
                REG_NEEDLE_LEN: needle_len = v[LEN_W-1:0];
                REG_LIMIT:      limit      = v[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function t_byte needle_byte(int k);
            logic [2*DATA_W-1:0] both;
            both = {needle_hi, needle_lo};
            return both[8*k +: 8];
        endfunction

        // bytes of the needle in use: length clamped, cut at the first zero byte
        function int needle_span();
            int n;
            n = (needle_len > NEEDLE_CAP) ? NEEDLE_CAP : int'(needle_len);
            for (int k = 0; k < n; k++) begin
                if (needle_byte(k) == 8'h00) return k;
            end
            return n;
        endfunction

        function void predict_byte(t_byte b, logic first);
            int             len;
            bit             hit;
            t_search_result r;
            if (first) restart_search();
            if (status == ST_SEARCH) begin
                len = needle_span();
                if (len == 0) begin
                    status   = ST_FOUND;
                    found_at = '0;
                end else if (b == 8'h00 || pos >= limit) begin
                    status = ST_MISS;
                end else begin
                    for (int k = NEEDLE_CAP - 1; k > 0; k--) window[k] = window[k-1];
                    window[0] = b;
                    hit = (pos >= IDX_W'(len - 1));
                    for (int k = 0; k < len; k++) begin
                        if (window[len-1-k] != needle_byte(k)) hit = 0;
                    end
                    if (hit) begin
                        status   = ST_FOUND;
                        found_at = pos - IDX_W'(len - 1);
                    end else if (pos != '1) begin
                        pos = pos + IDX_W'(1);
                    end
                end
            end
            r.status = status;
            r.start  = (status == ST_FOUND) ? found_at : '0;
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [IDX_W-1:0] ms);
            t_search_result e;
            results_seen++;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: search_status %0d match_start %0d", st, ms);
                errors++;
                return;
            end
            e = awaited_results.pop_front();
            if (st === ST_FOUND) found_seen++;
            if (st === ST_MISS) miss_seen++;
            if (st !== e.status) begin
                $error("search_status mismatch: expected %0d, actual %0d", e.status, st);
                errors++;
            end
            if (ms !== e.start) begin
                $error("match_start mismatch: expected %0d, actual %0d", e.start, ms);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    bss_in_if  hay ();
    bss_out_if res ();

    bounded_substring_search DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_hay   (hay.sink),
        .o_res   (res.source)
    );

    search_scoreboard sb;
    int    send_idle_pct;
    int    recv_idle_pct;
    bit    hold_req = 0;
    int    bytes_sent = 0;
    int    random_bytes = 0;
    int    stall_cycles = 0;
    t_byte cfg_needle [NEEDLE_CAP];
    int    cfg_len;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            sb.check_result(res.search_status, res.match_start);
        end
    end

    // watchdog: no transaction on either channel for too long
    always @(posedge i_clk) begin
        if ((hay.valid && hay.ready) || (res.valid && res.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("tb: errors");
            $finish;
        end
    end

    // result side back-pressure, with the occasional long hold-off
    initial begin
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
            end
            res.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic set_idling(input int ph);
        if (ph < 3) begin
            send_idle_pct = 16;
            recv_idle_pct = 78;
        end else if (ph < 6) begin
            send_idle_pct = 78;
            recv_idle_pct = 16;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input t_byte b, input logic first);
        while ($urandom_range(0, 99) < send_idle_pct) @(negedge i_clk);
        hay.valid      = 1'b1;
        hay.hay_byte   = b;
        hay.first_byte = first;
        do @(posedge i_clk); while (!hay.ready);
        sb.predict_byte(b, first);
        bytes_sent++;
        @(negedge i_clk);
        hay.valid = 1'b0;
    endtask

    task automatic wait_results();
        while (sb.pending() > 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx r, input logic [DATA_W-1:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {r, 3'b000};
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(r, v);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                             input logic [LEN_W-1:0] len, input logic [LIMIT_W-1:0] lim);
        logic [2*DATA_W-1:0] both;
        wait_results();
        apb_write(REG_NEEDLE_LO, lo);
        apb_write(REG_NEEDLE_HI, hi);
        apb_write(REG_NEEDLE_LEN, DATA_W'(len));
        apb_write(REG_LIMIT, DATA_W'(lim));
        both = {hi, lo};
        foreach (cfg_needle[k]) cfg_needle[k] = both[8*k +: 8];
        cfg_len = len;
    endtask

    task automatic random_config(input int ph);
        logic [2*DATA_W-1:0] needle;
        logic [LEN_W-1:0]    len;
        logic [LIMIT_W-1:0]  lim;
        int                  pick;
        bit                  any_byte;
        pick = $urandom_range(0, 9);
        if (ph == 2) len = 5'd31;
        else if (pick < 6) len = LEN_W'($urandom_range(1, 6));
        else if (pick < 8) len = LEN_W'($urandom_range(7, 16));
        else if (pick == 8) len = LEN_W'($urandom_range(17, 31));
        else len = '0;
        any_byte = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < NEEDLE_CAP; k++) begin
            if (k >= len) needle[8*k +: 8] = 8'($urandom_range(0, 255));
            else if (any_byte) needle[8*k +: 8] = 8'($urandom_range(1, 255));
            else needle[8*k +: 8] = 8'(8'h61 + $urandom_range(0, 2));
        end
        // now and then a zero byte cuts the needle short
        if ($urandom_range(0, 5) == 0) needle[8*$urandom_range(0, 15) +: 8] = 8'h00;
        case ($urandom_range(0, 3))
            0:       lim = '1;
            1:       lim = LIMIT_W'($urandom_range(10, 60));
            2:       lim = $urandom;
            default: lim = LIMIT_W'($urandom_range(0, 5));
        endcase
        configure(needle[DATA_W-1:0], needle[2*DATA_W-1:DATA_W], len, lim);
    endtask

    // one haystack: alphabet text with the needle planted now and then
    task automatic send_haystack(input bit broken);
        int    hay_len;
        int    plant_len;
        int    plant_at;
        bit    plant;
        t_byte b;
        plant_len = 0;
        while (plant_len < NEEDLE_CAP && plant_len < cfg_len && cfg_needle[plant_len] != 0) begin
            plant_len++;
        end
        hay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 30);
        plant = ($urandom_range(0, 1) == 1) && plant_len > 0 && plant_len <= hay_len;
        plant_at = plant ? $urandom_range(0, hay_len - plant_len) : 0;
        for (int k = 0; k < hay_len; k++) begin
            if (plant && k >= plant_at && k < plant_at + plant_len) b = cfg_needle[k-plant_at];
            else if ($urandom_range(0, 7) != 0) b = 8'(8'h61 + $urandom_range(0, 2));
            else b = 8'($urandom_range(1, 255));
            send_byte(b, (k == 0) && !broken);
            random_bytes++;
        end
        if ($urandom_range(0, 1) == 1) begin
            send_byte(8'h00, 1'b0);
            random_bytes++;
        end
        // trailing noise, mostly ignored once the search has ended
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial begin
        int  phase_start;
        bit  held;
        bit  paused;
        sb = new();
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        hay.valid      = 1'b0;
        hay.hay_byte   = '0;
        hay.first_byte = 1'b0;
        cfg_len        = 0;
        foreach (cfg_needle[k]) cfg_needle[k] = '0;
        held   = 0;
        paused = 0;
        set_idling(0);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // no first byte after reset, then bytes after the match are ignored
        configure(64'h6261, 64'h0, 5'd2, '1);
        send_byte(8'h78, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h71, 1'b0);
        // zero byte ends the haystack
        send_byte(8'h61, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h61, 1'b0);
        // match would straddle the limit
        configure(64'h6261, 64'h0, 5'd2, 32'd3);
        send_byte(8'h78, 1'b1);
        send_byte(8'h78, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        wait_results();
        apb_write(REG_LIMIT, '0);
        send_byte(8'h61, 1'b1);
        // oversized length with a zero byte inside the needle
        configure(64'h0000_0000_0080_01ff, '1, 5'd31, '1);
        send_byte(8'hff, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        // empty needle: found at the start, zero byte and zero limit included
        configure(64'hffff_ffff_ffff_ff00, 64'h0, 5'd5, '1);
        send_byte(8'h00, 1'b1);
        wait_results();
        apb_write(REG_NEEDLE_LEN, '0);
        apb_write(REG_LIMIT, '0);
        send_byte(8'h55, 1'b1);
        // needle changed in the middle of a haystack
        configure(64'h636261, 64'h0, 5'd3, '1);
        send_byte(8'h61, 1'b1);
        send_byte(8'h62, 1'b0);
        wait_results();
        apb_write(REG_NEEDLE_LO, 64'h7a62);
        apb_write(REG_NEEDLE_LEN, 64'd2);
        send_byte(8'h7a, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_idling(ph);
            random_config(ph);
            phase_start = random_bytes;
            while (random_bytes - phase_start < PHASE_BYTES) begin
                if (ph == 1 && !held && random_bytes - phase_start >= 80) begin
                    hold_req = 1;
                    held     = 1;
                end
                if (ph == 4 && !paused && random_bytes - phase_start >= 80) begin
                    wait_results();
                    paused = 1;
                end
                send_haystack($urandom_range(0, 19) == 0);
            end
        end

        wait_results();
        repeat (8) @(posedge i_clk);
        $display("summary: %0d haystack bytes over %0d needle settings, %0d results checked",
                 bytes_sent, PHASES + 6, sb.results_seen);
        $display("summary: %0d results found a match, %0d reported not found",
                 sb.found_seen, sb.miss_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
